@@ hdl/sackbl_pkg.sv @@
// Shared types, constants and sequence-compare helpers for the SACK block list.
package sackbl_pkg;

  localparam int MAX_BLOCKS_DEF = 4;
  localparam int SEQ_W          = 32;
  localparam int OUT_IDX_W      = 2;
  localparam int OUT_TOT_W      = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef enum logic {
    ACT_UPDATE = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a received range, restart the scan
    logic scan;    // examine one stored block
    logic commit;  // place the merged range at the head, fix the count
    logic clear;   // empty the list
    logic emit;    // load the next list word into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every stored block has been examined
    logic emit_last;  // the next word emitted closes the report
    logic out_free;   // output register can take a word this cycle
  } status_t;

  // Modulo 2^32 sequence compares: sign of the difference.
  function automatic logic seq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

  function automatic logic seq_gt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    return seq_lt(b, a);
  endfunction

  function automatic logic seq_leq(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    return !seq_lt(b, a);
  endfunction

  function automatic logic seq_geq(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    return !seq_lt(a, b);
  endfunction

endpackage

@@ hdl/sack_receiver_block_list_top.sv @@
// Top level of the receiver SACK block list: stream ports, controller and datapath.
//
// Keeps up to MAX_BLOCKS selective-acknowledgement blocks, most recent first.
// Input stream (in_*): one word is one action. in_tuser is the action flag
// (0 update with a received range, 1 clear the list); in_tdata carries the
// received range and the cumulative next-expected sequence number.
// Output stream (out_*): after every action the list is reported, one word per
// stored block in list order, out_tlast on the final word. An empty list gives
// a single word with out_tuser (block valid) low and all data zero.
// Sequence: an update is loaded, then the drop/merge scan examines one stored
// block per cycle, then come the end-of-scan check and the commit, then the
// report words are emitted one per cycle while out_tready does not stall. A
// clear goes straight to the report. The scan loop uses one shared merge unit.
// The first result word is loaded after the commit (clear: after the accept)
// once the output register is free, and out_tvalid rises in the cycle after
// the load. in_tready is high only while no action is in progress; a new
// action may be taken while the final result word still waits in the output
// register. A stall on out_tready holds the output word and the report.
// Reset (rst_n low, synchronous) empties the list and drops any word held.
module sack_receiver_block_list_top #(
  parameter int MAX_BLOCKS = sackbl_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] range_start, [63:32] range_end,
                                  // [95:64] next_expected
  input  logic        in_tuser,   // [0] action
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [1:0] block_index, [33:2] block_first,
                                  // [65:34] block_past, [68:66] block_total,
                                  // [71:69] zero
  output logic        out_tuser,  // [0] block_valid
  output logic        out_tlast   // last_result
);

  sackbl_pkg::cmd_t    cmd;
  sackbl_pkg::status_t sts;

  logic [sackbl_pkg::OUT_IDX_W-1:0] out_index;
  logic [sackbl_pkg::SEQ_W-1:0]     out_first, out_past;
  logic [sackbl_pkg::OUT_TOT_W-1:0] out_total;

  // Sequence the action: scan, commit, then report.
  sackbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_clear (in_tuser == sackbl_pkg::ACT_CLEAR),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the list, merge the range, drive the output word.
  sackbl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_start      (in_tdata[31:0]),
    .in_end        (in_tdata[63:32]),
    .in_next       (in_tdata[95:64]),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_blk_valid (out_tuser),
    .out_index     (out_index),
    .out_first     (out_first),
    .out_past      (out_past),
    .out_total     (out_total),
    .out_last      (out_tlast)
  );

  // Pack the result word, lowest field first.
  assign out_tdata = {3'b000, out_total, out_past, out_first, out_index};

endmodule

@@ hdl/sackbl_ctrl.sv @@
// Controller state machine: sequences load, scan, commit and report of the block list.
module sackbl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_clear,
  output logic                in_ready,
  input  sackbl_pkg::status_t sts,
  output sackbl_pkg::cmd_t    cmd
);

  sackbl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sackbl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sackbl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_clear ? sackbl_pkg::ST_EMIT : sackbl_pkg::ST_SCAN;
        end
      end
      sackbl_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = sackbl_pkg::ST_COMMIT;
        end
      end
      sackbl_pkg::ST_COMMIT: begin
        state_nxt = sackbl_pkg::ST_EMIT;
      end
      sackbl_pkg::ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_nxt = sackbl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sackbl_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      sackbl_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && !in_clear;
        cmd.clear = in_valid && in_clear;
      end
      sackbl_pkg::ST_SCAN: begin
        cmd.scan = !sts.scan_done;
      end
      sackbl_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      sackbl_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/sackbl_dp.sv @@
// Datapath: stored block list, merge unit, scan pointer and output word register.
module sackbl_dp #(
  parameter int MAX_BLOCKS = sackbl_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sackbl_pkg::cmd_t                     cmd,
  output sackbl_pkg::status_t                  sts,
  input  logic [sackbl_pkg::SEQ_W-1:0]         in_start,
  input  logic [sackbl_pkg::SEQ_W-1:0]         in_end,
  input  logic [sackbl_pkg::SEQ_W-1:0]         in_next,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_blk_valid,
  output logic [sackbl_pkg::OUT_IDX_W-1:0]     out_index,
  output logic [sackbl_pkg::SEQ_W-1:0]         out_first,
  output logic [sackbl_pkg::SEQ_W-1:0]         out_past,
  output logic [sackbl_pkg::OUT_TOT_W-1:0]     out_total,
  output logic                                 out_last
);

  localparam int SW    = sackbl_pkg::SEQ_W;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  logic [SW-1:0]    st_s_r [MAX_BLOCKS];
  logic [SW-1:0]    st_e_r [MAX_BLOCKS];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] ptr_r;
  logic [CNT_W-1:0] kept_r;
  logic [SW-1:0]    rs_r, re_r, nxt_r;
  logic             out_valid_r;

  logic                             out_blk_valid_r;
  logic [sackbl_pkg::OUT_IDX_W-1:0] out_index_r;
  logic [SW-1:0]                    out_first_r;
  logic [SW-1:0]                    out_past_r;
  logic [sackbl_pkg::OUT_TOT_W-1:0] out_total_r;
  logic                             out_last_r;

  logic [SW-1:0]    cur_s, cur_e;
  logic             drop, overlap, head;
  logic [CNT_W-1:0] count_nxt;

  assign cur_s   = st_s_r[ptr_r[IDX_W-1:0]];
  assign cur_e   = st_e_r[ptr_r[IDX_W-1:0]];
  assign drop    = sackbl_pkg::seq_geq(cur_s, cur_e) || sackbl_pkg::seq_leq(cur_s, nxt_r);
  assign overlap = sackbl_pkg::seq_leq(rs_r, cur_e) && sackbl_pkg::seq_geq(re_r, cur_s);
  assign head    = sackbl_pkg::seq_gt(rs_r, nxt_r);

  always_comb begin
    if (head) begin
      count_nxt = (kept_r >= MAX_CNT) ? MAX_CNT : kept_r + CNT_W'(1);
    end else begin
      count_nxt = kept_r;
    end
  end

  assign sts.scan_done = (ptr_r >= count_r);
  assign sts.emit_last = ((ptr_r + CNT_W'(1)) >= count_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr_r  <= '0;
        kept_r <= '0;
      end else if (cmd.scan) begin
        ptr_r <= ptr_r + CNT_W'(1);
        if (!drop && !overlap) begin
          kept_r <= kept_r + CNT_W'(1);
        end
      end else if (cmd.commit) begin
        count_r <= count_nxt;
        ptr_r   <= '0;
      end else if (cmd.clear) begin
        count_r <= '0;
        ptr_r   <= '0;
      end else if (cmd.emit) begin
        ptr_r <= ptr_r + CNT_W'(1);
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Merge range and stored list.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rs_r  <= in_start;
      re_r  <= in_end;
      nxt_r <= in_next;
    end else if (cmd.scan && !drop && overlap) begin
      // Widen the range over the touching block.
      if (sackbl_pkg::seq_gt(rs_r, cur_s)) rs_r <= cur_s;
      if (sackbl_pkg::seq_lt(re_r, cur_e)) re_r <= cur_e;
    end

    if (cmd.scan && !drop && !overlap) begin
      // Compact kept blocks toward the front in place.
      st_s_r[kept_r[IDX_W-1:0]] <= cur_s;
      st_e_r[kept_r[IDX_W-1:0]] <= cur_e;
    end else if (cmd.commit && head) begin
      // Shift kept blocks back one slot, oldest falls off when full.
      for (int j = 1; j < MAX_BLOCKS; j++) begin
        st_s_r[j] <= st_s_r[j-1];
        st_e_r[j] <= st_e_r[j-1];
      end
      st_s_r[0] <= rs_r;
      st_e_r[0] <= re_r;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_blk_valid_r <= (count_r != '0);
      out_index_r     <= sackbl_pkg::OUT_IDX_W'(ptr_r);
      out_first_r     <= (count_r != '0) ? cur_s : '0;
      out_past_r      <= (count_r != '0) ? cur_e : '0;
      out_total_r     <= sackbl_pkg::OUT_TOT_W'(count_r);
      out_last_r      <= sts.emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blk_valid = out_blk_valid_r;
  assign out_index     = out_index_r;
  assign out_first     = out_first_r;
  assign out_past      = out_past_r;
  assign out_total     = out_total_r;
  assign out_last      = out_last_r;

endmodule

@@ sim/sackbl_list_checker.sv @@
// Checker for the SACK block list: predicts every list report and compares output words.
`timescale 1ns / 100ps
module sackbl_list_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] range_start, [63:32] range_end,
                                  // [95:64] next_expected
  input  logic        in_tuser,   // [0] action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // [1:0] block_index, [33:2] block_first,
                                  // [65:34] block_past, [68:66] block_total, [71:69] zero
  input  logic        out_tuser,  // [0] block_valid
  input  logic        out_tlast,
  output int          fail_count,
  output int          words_pending
);

  localparam int LIST_DEPTH = sackbl_pkg::MAX_BLOCKS_DEF;

  typedef logic [sackbl_pkg::SEQ_W-1:0] seq_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    seq_t       first;
    seq_t       past;
    logic [2:0] total;
    logic       last;
    logic [2:0] pad;
  } sack_word_t;

  seq_t        list_first [LIST_DEPTH];
  seq_t        list_past  [LIST_DEPTH];
  int unsigned list_count = 0;
  sack_word_t  report_q [$];
  int          mismatches = 0;

  // True when a comes before b on the 2^32 sequence circle.
  function automatic bit seq_behind(seq_t a, seq_t b);
    return $signed(a - b) < 0;
  endfunction

  task automatic clear_list();
    for (int i = 0; i < LIST_DEPTH; i++) begin
      list_first[i] = '0;
      list_past[i]  = '0;
    end
    list_count = 0;
  endtask

  // Drop stale or empty blocks, fold touching ones into the range, keep the rest.
  task automatic merge_range(seq_t lo, seq_t hi, seq_t cum);
    seq_t        keep_first [LIST_DEPTH];
    seq_t        keep_past  [LIST_DEPTH];
    int unsigned kept = 0;
    int unsigned head = 0;
    for (int i = 0; i < list_count; i++) begin
      if (seq_behind(list_first[i], list_past[i]) && seq_behind(cum, list_first[i])) begin
        if (!seq_behind(list_past[i], lo) && !seq_behind(hi, list_first[i])) begin
          if (seq_behind(list_first[i], lo)) lo = list_first[i];
          if (seq_behind(hi, list_past[i])) hi = list_past[i];
        end else begin
          keep_first[kept] = list_first[i];
          keep_past[kept]  = list_past[i];
          kept++;
        end
      end
    end
    if (seq_behind(cum, lo)) begin
      list_first[0] = lo;
      list_past[0]  = hi;
      head = 1;
      if (kept == LIST_DEPTH) kept--;
    end
    for (int i = 0; i < kept; i++) begin
      list_first[head + i] = keep_first[i];
      list_past[head + i]  = keep_past[i];
    end
    list_count = head + kept;
  endtask

  task automatic queue_report();
    sack_word_t w;
    w = '0;
    if (list_count == 0) begin
      w.last = 1'b1;
      report_q.push_back(w);
    end else begin
      for (int k = 0; k < list_count; k++) begin
        w.valid = 1'b1;
        w.index = 2'(k);
        w.first = list_first[k];
        w.past  = list_past[k];
        w.total = 3'(list_count);
        w.last  = (k + 1 == list_count);
        report_q.push_back(w);
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sack_word_t got;
    sack_word_t want;
    if (!rst_n) begin
      clear_list();
      report_q.delete();
    end else begin
      // Retire output words before predicting a new action: the queue is in order.
      if (out_tvalid && out_tready) begin
        got.valid = out_tuser;
        got.index = out_tdata[1:0];
        got.first = out_tdata[33:2];
        got.past  = out_tdata[65:34];
        got.total = out_tdata[68:66];
        got.last  = out_tlast;
        got.pad   = out_tdata[71:69];
        if (report_q.size() == 0) begin
          $error("unexpected result word: block_first 0x%0h block_past 0x%0h",
                 got.first, got.past);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          check_field("block_valid", want.valid, got.valid);
          check_field("block_index", want.index, got.index);
          check_field("block_first", want.first, got.first);
          check_field("block_past", want.past, got.past);
          check_field("block_total", want.total, got.total);
          check_field("last_result", want.last, got.last);
          check_field("tdata padding", want.pad, got.pad);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == sackbl_pkg::ACT_CLEAR) clear_list();
        else merge_range(in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
        queue_report();
      end
    end
    fail_count    <= mismatches;
    words_pending <= report_q.size();
  end

endmodule

@@ sim/tb_sack_receiver_block_list_top.sv @@
// Testbench top for the SACK block list: clock, reset, action stimulus and verdict.
`timescale 1ns / 100ps
module tb_sack_receiver_block_list_top;

  // Random actions after the directed part; the final stretch runs without idling.
  localparam int RANDOM_ACTIONS = 305;
  localparam int CALM_ACTIONS   = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;   // [31:0] range_start, [63:32] range_end,
                                  // [95:64] next_expected
  logic        in_tuser   = 1'b0; // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;         // [1:0] block_index, [33:2] block_first,
                                  // [65:34] block_past, [68:66] block_total, [71:69] zero
  logic        out_tuser;         // [0] block_valid
  logic        out_tlast;

  int fail_count;
  int words_pending;

  // Idle knobs in percent per word: sender gaps and receiver stalls.
  int gap_pct    = 25;
  int stall_pct  = 25;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sack_receiver_block_list_top dut (.*);

  sackbl_list_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  // Receiver: stall out_tready in random bursts, else accept every word.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one action word and hold it until the block takes it. Valid stays high
  // between back-to-back words; drop it only when a gap burst is inserted.
  task automatic push_action(sackbl_pkg::action_t act, logic [31:0] lo, logic [31:0] hi,
                             logic [31:0] cum);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {cum, hi, lo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    logic [31:0] cum;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] swap;
    int          pick;

    // Hold reset, then release it once.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Range at or below next-expected on an empty list: empty report.
    push_action(sackbl_pkg::ACT_UPDATE, 32'd10, 32'd20, 32'd100);
    // Fill the list with four disjoint blocks, then overflow it.
    push_action(sackbl_pkg::ACT_UPDATE, 32'd100, 32'd200, 32'd50);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd300, 32'd400, 32'd50);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd500, 32'd600, 32'd50);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd700, 32'd800, 32'd50);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd900, 32'd1000, 32'd50);
    // Touching block merges; one range swallows three blocks.
    push_action(sackbl_pkg::ACT_UPDATE, 32'd1000, 32'd1100, 32'd50);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd350, 32'd750, 32'd50);
    // Advance next-expected past stored blocks.
    push_action(sackbl_pkg::ACT_UPDATE, 32'd1200, 32'd1300, 32'd650);
    // Empty range is stored, then dropped as empty on the next update.
    push_action(sackbl_pkg::ACT_UPDATE, 32'd2000, 32'd2000, 32'd1500);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd2100, 32'd2200, 32'd1500);
    // Reversed range is stored, then dropped as empty.
    push_action(sackbl_pkg::ACT_UPDATE, 32'd2600, 32'd2400, 32'd1500);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd2300, 32'd2500, 32'd1500);
    // Clear with all-ones payload, then ranges that wrap through zero.
    push_action(sackbl_pkg::ACT_CLEAR, '1, '1, '1);
    push_action(sackbl_pkg::ACT_UPDATE, 32'hFFFF_FF00, 32'h0000_0100, 32'hFFFF_FE00);
    push_action(sackbl_pkg::ACT_UPDATE, 32'h0000_0100, 32'h0000_0200, 32'hFFFF_FE00);
    // Start exactly half the sequence space ahead of next-expected.
    push_action(sackbl_pkg::ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_action(sackbl_pkg::ACT_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    // Start equal to next-expected: not stored; start just ahead of it: stored.
    push_action(sackbl_pkg::ACT_UPDATE, 32'h0, 32'h0, 32'h0);
    push_action(sackbl_pkg::ACT_UPDATE, '1, '1, 32'hFFFF_FFFE);
    // Full list, then clear it; clear an empty list too.
    push_action(sackbl_pkg::ACT_UPDATE, 32'd10, 32'd20, 32'd5);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd30, 32'd40, 32'd5);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd50, 32'd60, 32'd5);
    push_action(sackbl_pkg::ACT_UPDATE, 32'd70, 32'd80, 32'd5);
    push_action(sackbl_pkg::ACT_CLEAR, 32'h0, 32'h0, 32'h0);
    push_action(sackbl_pkg::ACT_CLEAR, 32'h0, 32'h0, 32'h0);

    // Random part: mostly segments of a simulated connection that arrive ahead of
    // next-expected on a 100-byte grid, so blocks touch, overlap and overflow.
    for (int n = 0; n < RANDOM_ACTIONS; n++) begin
      if (n == RANDOM_ACTIONS - CALM_ACTIONS) begin
        gap_pct    = 0;
        stall_pct <= 0;
      end else if (n % 60 == 0 && n < RANDOM_ACTIONS - CALM_ACTIONS) begin
        // Start a new connection, sometimes close to the wrap point.
        cum = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4095)
                                          : $urandom();
        case ($urandom_range(0, 3))
          0: begin
            gap_pct    = 40;
            stall_pct <= 40;
          end
          1: begin
            gap_pct    = 0;
            stall_pct <= 0;
          end
          2: begin
            gap_pct    = 50;
            stall_pct <= 0;
          end
          default: begin
            gap_pct    = 0;
            stall_pct <= 50;
          end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_action(sackbl_pkg::ACT_CLEAR, $urandom(), $urandom(), $urandom());
      end else if (pick < 14) begin
        // Noise: any value in every field.
        push_action(sackbl_pkg::ACT_UPDATE, $urandom(), $urandom(), $urandom());
      end else begin
        if (pick < 30) cum = cum + $urandom_range(1, 2500);
        lo = cum + $urandom_range(0, 24) * 100 - 200;
        if ($urandom_range(0, 3) == 0) lo = lo + $urandom_range(1, 99);
        hi = lo + $urandom_range(0, 6) * 100;
        if ($urandom_range(0, 24) == 0) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        push_action(sackbl_pkg::ACT_UPDATE, lo, hi, cum);
      end
    end
    in_tvalid <= 1'b0;

    // Drain: let the checker see the last word accepted, wait for every report
    // word, then keep running a while longer for stray output.
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_sack_receiver_block_list_top OK");
    end else begin
      $display("tb_sack_receiver_block_list_top NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_sack_receiver_block_list_top NOT OK");
    $finish;
  end

endmodule
